[rtl/swfr_pkg.sv]
// Shared types and constants for the stop-and-wait frame receiver.
package swfr_pkg;

  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam int unsigned SUM_W = 16;

  localparam logic [7:0] CH_UPPER_D = 8'h44;
  localparam logic [7:0] CH_LOWER_D = 8'h64;
  localparam logic [7:0] CH_UPPER_P = 8'h50;
  localparam logic [7:0] CH_LOWER_P = 8'h70;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_TWO     = 8'h32;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic [2:0] POS_FULL = 3'd4;

  typedef enum logic {
    REQ_HEADER  = 1'b0,
    REQ_PAYLOAD = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ACT_ACCEPT    = 2'd0,
    ACT_DUPLICATE = 2'd1,
    ACT_CORRUPT   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CLS_SEARCH  = 2'd0,
    CLS_SAVE    = 2'd1,
    CLS_INVALID = 2'd2
  } class_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] frame_seq;
    logic [31:0] frame_next_seq;
    logic [31:0] frame_checksum;
    logic        empty_payload;
    logic [7:0]  payload_byte;
    logic        last_byte;
  } item_t;

  typedef struct packed {
    logic fire;
    logic is_header;
    logic frame_end;
  } step_t;

endpackage

[rtl/swfr_ifs.sv]
// Valid/ready channel interfaces for frame items and result items.
interface swfr_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] frame_seq;
  logic signed [31:0] frame_next_seq;
  logic        [31:0] frame_checksum;
  logic               empty_payload;
  logic        [7:0]  payload_byte;
  logic               last_byte;

  modport source (
    output valid, req_type, frame_seq, frame_next_seq, frame_checksum,
    output empty_payload, payload_byte, last_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, frame_seq, frame_next_seq, frame_checksum,
    input  empty_payload, payload_byte, last_byte,
    output ready
  );
endinterface

interface swfr_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  action;
  logic signed [31:0] ack_number;
  logic        [1:0]  request_class;
  logic        [1:0]  fuel_type;
  logic        [31:0] computed_checksum;

  modport source (
    output valid, action, ack_number, request_class, fuel_type, computed_checksum,
    input  ready
  );
  modport sink (
    input  valid, action, ack_number, request_class, fuel_type, computed_checksum,
    output ready
  );
endinterface

[rtl/swfr_checksum.sv]
// Running Adler-32 sums over the payload bytes of one frame.
module swfr_checksum (
  input  logic                clk,
  input  logic                rst,
  input  swfr_pkg::step_t     step,
  input  logic [7:0]          data,
  output logic [31:0]         sum
);
  import swfr_pkg::*;

  logic [SUM_W-1:0] sum_low;
  logic [SUM_W-1:0] sum_high;
  logic [SUM_W-1:0] low_upd;
  logic [SUM_W-1:0] high_upd;
  logic [SUM_W:0]   low_add;
  logic [SUM_W:0]   high_add;

  always_comb begin
    low_add = {1'b0, sum_low} + {9'd0, data};
    if (low_add >= ADLER_MOD) begin
      low_add = low_add - ADLER_MOD;
    end
    low_upd = low_add[SUM_W-1:0];
    high_add = {1'b0, sum_high} + {1'b0, low_upd};
    if (high_add >= ADLER_MOD) begin
      high_add = high_add - ADLER_MOD;
    end
    high_upd = high_add[SUM_W-1:0];
  end

  assign sum = step.is_header ? 32'd1 : {high_upd, low_upd};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_low  <= 16'd1;
      sum_high <= 16'd0;
    end else if (step.fire) begin
      if (step.is_header || step.frame_end) begin
        sum_low  <= 16'd1;
        sum_high <= 16'd0;
      end else begin
        sum_low  <= low_upd;
        sum_high <= high_upd;
      end
    end
  end

endmodule

[rtl/swfr_classify.sv]
// Request format check on the first four payload bytes of a frame.
module swfr_classify (
  input  logic                clk,
  input  logic                rst,
  input  swfr_pkg::step_t     step,
  input  logic [7:0]          data,
  output swfr_pkg::class_t    req_class,
  output logic [1:0]          fuel
);
  import swfr_pkg::*;

  logic [2:0] byte_position;
  logic       header_valid;
  logic       is_save;
  logic [1:0] held_fuel;
  logic [2:0] pos_upd;
  logic       valid_upd;
  logic       save_upd;
  logic [1:0] fuel_upd;
  logic       complete;

  always_comb begin
    valid_upd = header_valid;
    save_upd  = is_save;
    fuel_upd  = held_fuel;
    case (byte_position)
      3'd0: begin
        if (data == CH_UPPER_D || data == CH_LOWER_D) begin
          save_upd = 1'b1;
        end else if (data == CH_UPPER_P || data == CH_LOWER_P) begin
          save_upd = 1'b0;
        end else begin
          valid_upd = 1'b0;
        end
      end
      3'd1, 3'd3: begin
        if (data != CH_SPACE) begin
          valid_upd = 1'b0;
        end
      end
      3'd2: begin
        if (data >= CH_ZERO && data <= CH_TWO) begin
          fuel_upd = 2'(data - CH_ZERO);
        end else begin
          valid_upd = 1'b0;
        end
      end
      default: begin
      end
    endcase
    pos_upd  = (byte_position < POS_FULL) ? byte_position + 3'd1 : byte_position;
    complete = valid_upd && (pos_upd >= POS_FULL) && !step.is_header;
    if (!complete) begin
      req_class = CLS_INVALID;
      fuel      = 2'd0;
    end else begin
      req_class = save_upd ? CLS_SAVE : CLS_SEARCH;
      fuel      = fuel_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 3'd0;
      header_valid  <= 1'b1;
      is_save       <= 1'b0;
      held_fuel     <= 2'd0;
    end else if (step.fire) begin
      if (step.is_header || step.frame_end) begin
        byte_position <= 3'd0;
        header_valid  <= 1'b1;
        is_save       <= 1'b0;
        held_fuel     <= 2'd0;
      end else begin
        byte_position <= pos_upd;
        header_valid  <= valid_upd;
        is_save       <= save_upd;
        held_fuel     <= fuel_upd;
      end
    end
  end

endmodule

[rtl/stop_wait_frame_receiver.sv]
// Stop-and-wait receiver: input register, frame decision, result register.
// An accepted transaction waits in the input register until the frame decision takes it;
// an untaken result stalls that decision. A frame's result goes to the result register.
// Throughput is one transaction per cycle while the result register does not stall.
// Synchronous reset clears valid flags, sequence state and running sums.
module stop_wait_frame_receiver (
  input logic       clk,
  input logic       rst,
  swfr_in_if.sink   frame,
  swfr_out_if.source result
);
  import swfr_pkg::*;

  item_t       held;
  logic        held_valid;
  logic [31:0] expected_seq;
  logic [31:0] last_ack;
  logic [31:0] held_next_seq;
  logic [31:0] held_checksum;
  logic        seq_matches;

  logic        is_header;
  logic        produce;
  logic        advance;
  step_t       step;
  logic [31:0] sum;
  class_t      req_class;
  logic [1:0]  fuel;
  logic [31:0] eff_next;
  logic [31:0] eff_checksum;
  logic        eff_match;
  action_t     act;
  logic [31:0] ack;

  logic        out_valid;
  action_t     out_action;
  logic [31:0] out_ack;
  class_t      out_class;
  logic [1:0]  out_fuel;
  logic [31:0] out_sum;

  assign is_header = (held.req_type == REQ_HEADER);
  assign produce   = is_header ? held.empty_payload : held.last_byte;
  assign advance   = held_valid && (!produce || !out_valid || result.ready);
  assign frame.ready = !held_valid || advance;

  assign step.fire      = advance;
  assign step.is_header = is_header;
  assign step.frame_end = produce;

  swfr_checksum u_checksum (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .data (held.payload_byte),
    .sum  (sum)
  );

  swfr_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data      (held.payload_byte),
    .req_class (req_class),
    .fuel      (fuel)
  );

  always_comb begin
    eff_next     = is_header ? held.frame_next_seq : held_next_seq;
    eff_checksum = is_header ? held.frame_checksum : held_checksum;
    eff_match    = is_header ? (held.frame_seq == expected_seq) : seq_matches;
    if (!eff_match) begin
      act = ACT_DUPLICATE;
      ack = last_ack;
    end else if (sum != eff_checksum) begin
      act = ACT_CORRUPT;
      ack = last_ack;
    end else begin
      act = ACT_ACCEPT;
      ack = eff_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (frame.ready) begin
      held_valid <= frame.valid;
    end
    if (frame.ready && frame.valid) begin
      held.req_type       <= frame.req_type;
      held.frame_seq      <= frame.frame_seq;
      held.frame_next_seq <= frame.frame_next_seq;
      held.frame_checksum <= frame.frame_checksum;
      held.empty_payload  <= frame.empty_payload;
      held.payload_byte   <= frame.payload_byte;
      held.last_byte      <= frame.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_seq  <= 32'd0;
      last_ack      <= 32'd0;
      held_next_seq <= 32'd0;
      held_checksum <= 32'd0;
      seq_matches   <= 1'b0;
    end else if (advance) begin
      if (is_header) begin
        held_next_seq <= held.frame_next_seq;
        held_checksum <= held.frame_checksum;
        seq_matches   <= eff_match;
      end
      if (produce && act == ACT_ACCEPT) begin
        expected_seq <= eff_next;
        last_ack     <= eff_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && produce) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (advance && produce) begin
      out_action <= act;
      out_ack    <= ack;
      out_class  <= req_class;
      out_fuel   <= fuel;
      out_sum    <= sum;
    end
  end

  assign result.valid             = out_valid;
  assign result.action            = out_action;
  assign result.ack_number        = out_ack;
  assign result.request_class     = out_class;
  assign result.fuel_type         = out_fuel;
  assign result.computed_checksum = out_sum;

endmodule

[sim/stop_wait_frame_receiver_test.sv]
// Self-checking testbench for the stop-and-wait frame receiver with Adler-32 check.
`timescale 1ns / 100ps

module stop_wait_frame_receiver_test;
  import swfr_pkg::*;

  localparam int ITEM_COUNT  = 2000;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 10;
  localparam int HOLD_CYCLES = 300;

  typedef logic [7:0] octets_t[$];

  typedef struct {
    action_t     action;
    logic [31:0] ack;
    class_t      cls;
    logic [1:0]  fuel;
    logic [31:0] adler;
  } verdict_t;

  class frame_verdicts;
    logic [31:0] wanted_seq;
    logic [31:0] resend_ack;
    logic [31:0] announced_next;
    logic [31:0] sent_adler;
    logic [15:0] adler_a;
    logic [15:0] adler_b;
    logic [2:0]  byte_idx;
    bit          seq_hit;
    bit          format_ok;
    bit          save_req;
    logic [1:0]  fuel_digit;
    verdict_t    pending[$];
    int          mismatches;
    int          checked;
    int          accepts;
    int          dups;
    int          corrupts;

    function new();
      wanted_seq = '0;
      resend_ack = '0;
      announced_next = '0;
      sent_adler = '0;
      seq_hit = 1'b0;
      mismatches = 0;
      checked = 0;
      accepts = 0;
      dups = 0;
      corrupts = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      adler_a = 16'd1;
      adler_b = 16'd0;
      byte_idx = '0;
      format_ok = 1'b1;
      save_req = 1'b0;
      fuel_digit = '0;
    endfunction

    function void close_frame();
      verdict_t v;
      bit       well_formed;
      v.adler = {adler_b, adler_a};
      well_formed = format_ok && byte_idx >= POS_FULL;
      if (!seq_hit) begin
        v.action = ACT_DUPLICATE;
        v.ack = resend_ack;
        dups++;
      end else if (v.adler != sent_adler) begin
        v.action = ACT_CORRUPT;
        v.ack = resend_ack;
        corrupts++;
      end else begin
        v.action = ACT_ACCEPT;
        resend_ack = announced_next;
        wanted_seq = announced_next;
        v.ack = announced_next;
        accepts++;
      end
      v.cls = well_formed ? (save_req ? CLS_SAVE : CLS_SEARCH) : CLS_INVALID;
      v.fuel = well_formed ? fuel_digit : 2'd0;
      pending.push_back(v);
      restart_frame();
    endfunction

    function void take_item(item_t it);
      logic [16:0] acc;
      logic [7:0]  b;
      if (it.req_type == REQ_HEADER) begin
        announced_next = it.frame_next_seq;
        sent_adler = it.frame_checksum;
        seq_hit = (it.frame_seq == wanted_seq);
        restart_frame();
        if (it.empty_payload) close_frame();
      end else begin
        b = it.payload_byte;
        acc = {1'b0, adler_a} + b;
        if (acc >= ADLER_MOD) acc = acc - ADLER_MOD;
        adler_a = acc[15:0];
        acc = {1'b0, adler_b} + adler_a;
        if (acc >= ADLER_MOD) acc = acc - ADLER_MOD;
        adler_b = acc[15:0];
        case (byte_idx)
          3'd0: begin
            if (b == CH_UPPER_D || b == CH_LOWER_D) save_req = 1'b1;
            else if (b == CH_UPPER_P || b == CH_LOWER_P) save_req = 1'b0;
            else format_ok = 1'b0;
          end
          3'd1, 3'd3: begin
            if (b != CH_SPACE) format_ok = 1'b0;
          end
          3'd2: begin
            if (b >= CH_ZERO && b <= CH_TWO) fuel_digit = 2'(b - CH_ZERO);
            else format_ok = 1'b0;
          end
          default: ;
        endcase
        if (byte_idx < POS_FULL) byte_idx++;
        if (it.last_byte) close_frame();
      end
    endfunction

    function void check_verdict(logic [1:0] action, logic [31:0] ack, logic [1:0] cls,
                                logic [1:0] fuel, logic [31:0] adler);
      verdict_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with no frame pending: action %0d ack %h", $time, action, ack);
        mismatches++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (action !== want.action) begin
        $display("%0t: action expected %0d actual %0d", $time, want.action, action);
        mismatches++;
      end
      if (ack !== want.ack) begin
        $display("%0t: ack_number expected %h actual %h", $time, want.ack, ack);
        mismatches++;
      end
      if (cls !== want.cls) begin
        $display("%0t: request_class expected %0d actual %0d", $time, want.cls, cls);
        mismatches++;
      end
      if (fuel !== want.fuel) begin
        $display("%0t: fuel_type expected %0d actual %0d", $time, want.fuel, fuel);
        mismatches++;
      end
      if (adler !== want.adler) begin
        $display("%0t: computed_checksum expected %h actual %h", $time, want.adler, adler);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   items_sent;
  int   cycles;
  bit   tx_calm;

  frame_verdicts board = new();

  swfr_in_if  frame_if ();
  swfr_out_if result_if ();

  stop_wait_frame_receiver i_dut (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame_if),
    .result (result_if)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [31:0] adler_of(input octets_t data);
    int unsigned a;
    int unsigned b;
    a = 1;
    b = 0;
    foreach (data[i]) begin
      a = (a + data[i]) % 65521;
      b = (b + a) % 65521;
    end
    return {b[15:0], a[15:0]};
  endfunction

  task automatic offer(input item_t it);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      frame_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frame_if.valid          <= 1'b1;
    frame_if.req_type       <= it.req_type;
    frame_if.frame_seq      <= it.frame_seq;
    frame_if.frame_next_seq <= it.frame_next_seq;
    frame_if.frame_checksum <= it.frame_checksum;
    frame_if.empty_payload  <= it.empty_payload;
    frame_if.payload_byte   <= it.payload_byte;
    frame_if.last_byte      <= it.last_byte;
    do @(posedge clk); while (!frame_if.ready);
    board.take_item(it);
    items_sent++;
  endtask

  task automatic send_frame(input logic [31:0] seq, input logic [31:0] next,
                            input logic [31:0] chk, input octets_t data,
                            input bit with_header, input bit finish);
    item_t it;
    if (with_header) begin
      it.req_type       = REQ_HEADER;
      it.frame_seq      = seq;
      it.frame_next_seq = next;
      it.frame_checksum = chk;
      it.empty_payload  = (data.size() == 0) && finish;
      it.payload_byte   = 8'($urandom);
      it.last_byte      = 1'($urandom);
      offer(it);
    end
    foreach (data[i]) begin
      it.req_type       = REQ_PAYLOAD;
      it.frame_seq      = $urandom;
      it.frame_next_seq = $urandom;
      it.frame_checksum = $urandom;
      it.empty_payload  = 1'($urandom);
      it.payload_byte   = data[i];
      it.last_byte      = finish && (i == data.size() - 1);
      offer(it);
    end
  endtask

  task automatic random_frame();
    octets_t     data;
    int          len;
    int          r;
    logic [31:0] seq;
    logic [31:0] next;
    logic [31:0] chk;
    r = $urandom_range(0, 99);
    if (r < 70) seq = board.wanted_seq;
    else if (r < 88) seq = board.wanted_seq - $urandom_range(1, 3);
    else seq = $urandom;
    next = ($urandom_range(0, 3) == 0) ? 32'($urandom) : board.wanted_seq + 1;
    r = $urandom_range(0, 99);
    if (r < 10) len = 0;
    else if (r < 90) len = $urandom_range(1, 12);
    else len = $urandom_range(13, 40);
    for (int i = 0; i < len; i++) data.push_back(8'($urandom));
    if (len > 0 && $urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 3))
        0: data[0] = CH_UPPER_D;
        1: data[0] = CH_LOWER_D;
        2: data[0] = CH_UPPER_P;
        default: data[0] = CH_LOWER_P;
      endcase
      if (len > 1) data[1] = CH_SPACE;
      if (len > 2) begin
        r = $urandom_range(0, 9);
        if (r == 0) data[2] = CH_ZERO - 8'd1;
        else if (r == 1) data[2] = CH_TWO + 8'd1;
        else data[2] = CH_ZERO + 8'($urandom_range(0, 2));
      end
      if (len > 3) data[3] = CH_SPACE;
      if ($urandom_range(0, 9) == 0) data[$urandom_range(0, len - 1)] = 8'($urandom);
    end
    chk = adler_of(data);
    r = $urandom_range(0, 7);
    if (r == 0) chk = chk ^ (32'd1 << $urandom_range(0, 31));
    else if (r == 1) chk = $urandom;
    send_frame(seq, next, chk, data, $urandom_range(0, 29) != 0, $urandom_range(0, 19) != 0);
  endtask

  initial begin
    int          stall_left;
    int          hold_left;
    bit          rx_calm;
    stall_left = 0;
    hold_left = 0;
    rx_calm = 1'b0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_if.valid && result_if.ready) begin
        board.check_verdict(result_if.action, result_if.ack_number, result_if.request_class,
                            result_if.fuel_type, result_if.computed_checksum);
        if (board.checked == 40 || board.checked == 1000) hold_left = HOLD_CYCLES;
      end
      if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        stall_left = pick_gap(rx_calm);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped after %0d cycles with %0d results outstanding", cycles,
             board.pending.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    octets_t data;
    items_sent = 0;
    tx_calm = 1'b0;
    rst <= 1'b1;
    frame_if.valid          <= 1'b0;
    frame_if.req_type       <= REQ_HEADER;
    frame_if.frame_seq      <= '0;
    frame_if.frame_next_seq <= '0;
    frame_if.frame_checksum <= '0;
    frame_if.empty_payload  <= 1'b0;
    frame_if.payload_byte   <= '0;
    frame_if.last_byte      <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // A lone zero byte with no header closes a frame on the reset header values.
    data = '{8'h00};
    send_frame('0, '0, '0, data, 1'b0, 1'b1);
    data = {};
    send_frame(32'h0000_0000, 32'h7fff_ffff, 32'h0000_0001, data, 1'b1, 1'b1);
    data = '{CH_UPPER_D, CH_SPACE, CH_ZERO + 8'd1, CH_SPACE};
    send_frame(32'h7fff_ffff, 32'h8000_0000, adler_of(data), data, 1'b1, 1'b1);
    data = '{CH_LOWER_P, CH_SPACE, CH_TWO, CH_SPACE};
    send_frame(32'h8000_0000, 32'h0000_0000, 32'hffff_ffff, data, 1'b1, 1'b1);
    data = '{CH_UPPER_P, CH_SPACE, CH_ZERO, CH_SPACE};
    send_frame(32'h7fff_ffff, 32'h0000_0005, adler_of(data), data, 1'b1, 1'b1);
    // A new header arrives before the open frame has ended.
    data = '{CH_LOWER_D};
    send_frame(32'h8000_0000, 32'h1234_5678, 32'h0000_0000, data, 1'b1, 1'b0);
    data = '{8'hff, 8'h00};
    send_frame(32'h8000_0000, 32'hffff_ffff, adler_of(data), data, 1'b1, 1'b1);
    data = {};
    send_frame(32'hffff_ffff, 32'h0000_0000, 32'h0000_0000, data, 1'b1, 1'b1);

    while (items_sent < ITEM_COUNT) random_frame();
    frame_if.valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d input transactions and checked %0d frame results", items_sent,
             board.checked);
    $display("Results: %0d accepted, %0d duplicate, %0d corrupt; %0d mismatches",
             board.accepts, board.dups, board.corrupts, board.mismatches);
    if (board.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
